// File: src/aescbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_pkg
// Shared constants, types and byte functions of the AES-CBC block decryptor.
// ----------------------------------------------------------------------------
package aescbc_pkg;

   localparam int KEY_WORDS = 4;
   localparam int NR        = KEY_WORDS + 6;
   localparam int RK_ROWS   = NR + 1;
   localparam int RK_WORDS  = 4 * RK_ROWS;
   localparam int RK_ADDR_W = $clog2(RK_ROWS);
   localparam int CNT_W     = $clog2(RK_WORDS);
   localparam int MOD_W     = $clog2(KEY_WORDS);
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_HIGH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_LOW  = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND
   } dec_state_type;

   typedef struct packed {
      logic                 en;
      logic [RK_ADDR_W-1:0] addr;
      logic [127:0]         data;
   } rk_wr_type;

   localparam logic [2047:0] SBOX_ROM = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_ROM = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_ROM[2047 - 8 * int'(x) -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_ROM[2047 - 8 * int'(x) -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // byte n of the state sits at bits 127-8n; column c is bytes 4c..4c+3
   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      int           src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = ((c + 4 - r) % 4) * 4 + r;
            t[127 - 8 * (c * 4 + r) -: 8] = inv_sbox(s[127 - 8 * src -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [3:0][7:0] x;
      logic [3:0][7:0] m9, mb, md, me;
      logic [7:0]      x2, x4, x8;
      x = w;
      for (int k = 0; k < 4; k++) begin
         x2 = xtime(x[k]);
         x4 = xtime(x2);
         x8 = xtime(x4);
         m9[k] = x8 ^ x[k];
         mb[k] = x8 ^ x2 ^ x[k];
         md[k] = x8 ^ x4 ^ x[k];
         me[k] = x8 ^ x4 ^ x2;
      end
      // x[3] is row 0, x[0] is row 3
      return {me[3] ^ mb[2] ^ md[1] ^ m9[0],
              m9[3] ^ me[2] ^ mb[1] ^ md[0],
              md[3] ^ m9[2] ^ me[1] ^ mb[0],
              mb[3] ^ md[2] ^ m9[1] ^ me[0]};
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         t[127 - 32 * c -: 32] = inv_mix_col(s[127 - 32 * c -: 32]);
      end
      return t;
   endfunction

endpackage

// File: src/aescbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aescbc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/aescbc_keyexp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_keyexp
// Key schedule sequencer: one key word per cycle, one round-key row written
// to the round-key RAM every four words.
// ----------------------------------------------------------------------------
module aescbc_keyexp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [3:0][63:0]     keys,
   output logic                 busy,
   output aescbc_pkg::rk_wr_type rk_wr
);

   logic                                   busy_ff, busy_in;
   logic [aescbc_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [aescbc_pkg::MOD_W-1:0]           mod_ff, mod_in;
   logic [7:0]                             rcon_ff, rcon_in;
   logic [aescbc_pkg::KEY_WORDS-1:0][31:0] win_ff, win_in;
   logic [95:0]                            row_ff, row_in;
   logic [31:0]                            key_word, tmp, word;

   always_comb begin
      key_word = cnt_ff[0] ? keys[cnt_ff[2:1]][31:0] : keys[cnt_ff[2:1]][63:32];
      tmp = win_ff[aescbc_pkg::KEY_WORDS-1];
      if (mod_ff == '0) begin
         tmp = aescbc_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (aescbc_pkg::KEY_WORDS > 6 && mod_ff == aescbc_pkg::MOD_W'(4)) begin
         tmp = aescbc_pkg::sub_word(tmp);
      end
      if (cnt_ff < aescbc_pkg::CNT_W'(aescbc_pkg::KEY_WORDS)) begin
         word = key_word;
      end else begin
         word = win_ff[0] ^ tmp;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mod_in  = mod_ff;
      rcon_in = rcon_ff;
      win_in  = win_ff;
      row_in  = row_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mod_in  = '0;
         rcon_in = 8'h01;
      end else if (busy_ff) begin
         for (int k = 0; k < aescbc_pkg::KEY_WORDS - 1; k++) begin
            win_in[k] = win_ff[k + 1];
         end
         win_in[aescbc_pkg::KEY_WORDS-1] = word;
         row_in = {row_ff[63:0], word};
         if (mod_ff == aescbc_pkg::MOD_W'(aescbc_pkg::KEY_WORDS - 1)) begin
            mod_in = '0;
         end else begin
            mod_in = mod_ff + 1'b1;
         end
         if (mod_ff == '0 && cnt_ff >= aescbc_pkg::CNT_W'(aescbc_pkg::KEY_WORDS)) begin
            rcon_in = aescbc_pkg::xtime(rcon_ff);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == aescbc_pkg::CNT_W'(aescbc_pkg::RK_WORDS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      mod_ff  <= mod_in;
      rcon_ff <= rcon_in;
      win_ff  <= win_in;
      row_ff  <= row_in;
   end

   assign busy       = busy_ff;
   assign rk_wr.en   = busy_ff && cnt_ff[1:0] == 2'd3;
   assign rk_wr.addr = aescbc_pkg::RK_ADDR_W'(cnt_ff >> 2);
   assign rk_wr.data = {row_ff, word};

endmodule

// File: src/aes_cbc_block_decryptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC block decryptor
// Decrypts one 128-bit ciphertext block per transaction and chains CBC-style.
// ----------------------------------------------------------------------------
// Channels: req_ carries a ciphertext block (byte 0 in req_cipher_high[63:56])
// and req_first_block, which chains from the IV instead of the previous
// ciphertext. rsp_ returns the plaintext block. csr_ writes key_0..key_3
// (index 0..3), iv_high (4) and iv_low (5); other indices are ignored.
// A key write starts the key schedule: a start pulse, then all RK_WORDS
// round-key words, one word per cycle; while these run, csr_ready
// and req_ready are low.
// The round keys live in a one-read, one-write RAM of Nr+1 rows.
// From acceptance to rsp_valid: the initial key addition, then one inverse
// round per cycle through the shared round logic, the last one loading the
// output register and holding while that register is full. The RAM
// address runs one round ahead of the data. One block is in flight at a time
// and req_ready returns once the result is loaded, so a new block is only
// taken after the previous one has left the round logic.
// The result sits in an output register: a new block is accepted while it
// waits; if the receiver still stalls at the last round, the round logic
// holds until the output register frees.
// Reset clears the chaining value, key and IV registers; round keys are
// undefined until a key register is written.
// ----------------------------------------------------------------------------
module aes_cbc_block_decryptor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [63:0]                      req_cipher_high,
   input  logic [63:0]                      req_cipher_low,
   input  logic                             req_first_block,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [63:0]                      rsp_plain_high,
   output logic [63:0]                      rsp_plain_low,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aescbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                      csr_data
);

   aescbc_pkg::dec_state_type            state_ff, state_in;
   logic [aescbc_pkg::RK_ADDR_W-1:0]     rnd_ff, rnd_in, rd_addr;
   logic [127:0]                         blk_ff, blk_in, cv_ff, cv_in, rd_data, round_out;
   logic [127:0]                         chain_ff, chain_in, out_ff, out_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [3:0][63:0]                     key_ff;
   logic [127:0]                         iv_ff;
   logic                                 kx_start_ff, kx_busy;
   aescbc_pkg::rk_wr_type                rk_wr;
   logic                                 req_acc, csr_acc, out_free, finish;

   assign csr_ready = !kx_busy && !kx_start_ff;
   assign req_ready = state_ff == aescbc_pkg::ST_IDLE && !kx_busy && !kx_start_ff;
   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign round_out = aescbc_pkg::inv_shift_sub(blk_ff) ^ rd_data;
   assign finish    = state_ff == aescbc_pkg::ST_ROUND && rnd_ff == '0 && out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         iv_ff       <= '0;
         kx_start_ff <= 1'b0;
      end else begin
         kx_start_ff <= 1'b0;
         if (csr_acc) begin
            case (csr_index)
               aescbc_pkg::CSR_KEY_0, aescbc_pkg::CSR_KEY_1,
               aescbc_pkg::CSR_KEY_2, aescbc_pkg::CSR_KEY_3: begin
                  key_ff[csr_index[1:0]] <= csr_data;
                  kx_start_ff            <= 1'b1;
               end
               aescbc_pkg::CSR_IV_HIGH: iv_ff[127:64] <= csr_data;
               aescbc_pkg::CSR_IV_LOW:  iv_ff[63:0]   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   aescbc_keyexp u_keyexp (
      .clock (clock),
      .reset (reset),
      .start (kx_start_ff),
      .keys  (key_ff),
      .busy  (kx_busy),
      .rk_wr (rk_wr)
   );

   aescbc_ram #(
      .WIDTH (128),
      .DEPTH (aescbc_pkg::RK_ROWS)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (rk_wr.en),
      .wr_addr (rk_wr.addr),
      .wr_data (rk_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aescbc_pkg::ST_IDLE:  if (req_acc) state_in = aescbc_pkg::ST_INIT;
         aescbc_pkg::ST_INIT:  state_in = aescbc_pkg::ST_ROUND;
         aescbc_pkg::ST_ROUND: if (finish) state_in = aescbc_pkg::ST_IDLE;
         default:              state_in = aescbc_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM address; the address is one round ahead of the data
   always_comb begin
      blk_in       = blk_ff;
      cv_in        = cv_ff;
      chain_in     = chain_ff;
      rnd_in       = rnd_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = aescbc_pkg::RK_ADDR_W'(aescbc_pkg::NR);
      case (state_ff)
         aescbc_pkg::ST_IDLE: begin
            if (req_acc) begin
               blk_in   = {req_cipher_high, req_cipher_low};
               cv_in    = req_first_block ? iv_ff : chain_ff;
               chain_in = {req_cipher_high, req_cipher_low};
               rnd_in   = aescbc_pkg::RK_ADDR_W'(aescbc_pkg::NR - 1);
            end
         end
         aescbc_pkg::ST_INIT: begin
            blk_in  = blk_ff ^ rd_data;
            rd_addr = rnd_ff;
         end
         aescbc_pkg::ST_ROUND: begin
            rd_addr = rnd_ff;
            if (rnd_ff != '0) begin
               blk_in  = aescbc_pkg::inv_mix(round_out);
               rnd_in  = rnd_ff - 1'b1;
               rd_addr = rnd_ff - 1'b1;
            end else if (out_free) begin
               out_in       = round_out ^ cv_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aescbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
      blk_ff <= blk_in;
      cv_ff  <= cv_in;
      rnd_ff <= rnd_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_high = out_ff[127:64];
   assign rsp_plain_low  = out_ff[63:0];

   a_kx_idle: assert property (@(posedge clock) disable iff (reset)
      kx_busy |-> state_ff == aescbc_pkg::ST_IDLE)
      else $error("key schedule running while a block is in flight");

   a_acc_init: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == aescbc_pkg::ST_INIT)
      else $error("accepted block did not start");

   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == aescbc_pkg::ST_ROUND && rnd_ff == '0 && rsp_valid_ff && !rsp_ready
      |=> state_ff == aescbc_pkg::ST_ROUND && rnd_ff == '0)
      else $error("last round left while output register full");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == aescbc_pkg::ST_ROUND)
      else $error("result raised outside the last round");

endmodule
